### design/sorted_encoder_event_table_macros.svh
// Assertion macros for the sorted encoder event table.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef SORTED_ENCODER_EVENT_TABLE_MACROS_SVH
`define SORTED_ENCODER_EVENT_TABLE_MACROS_SVH
`ifndef SYNTH
`define SETB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SETB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SETB_ASSERT(lbl, clk, rstn, prop, msg)
`define SETB_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### design/setb_pkg.sv
// Shared types and codes for the sorted encoder event table.
// No dependencies; used by the cell, the top level, the checker and the testbench.
`timescale 1ns / 1ps
package setb_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_REWIND = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] count;
    logic [3:0]  channel;
    logic [1:0]  kind;
  } entry_t;

  // Broadcast to every cell for the word being worked on
  typedef struct packed {
    logic   clear;
    logic   insert;
    logic   remove;
    entry_t ent;
  } op_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic        valid;
    entry_t      ent;
    logic        after;
    logic        found;
    logic [15:0] last;
  } cell_out_t;

endpackage

### design/setb_if.sv
// Valid/ready channel interfaces for event words and result words.
// Depends on nothing; payload widths follow the table's field list.
`timescale 1ns / 1ps
interface setb_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] event_count;
  logic [3:0]  event_channel;
  logic [1:0]  event_kind;

  modport source (output valid, action, event_count, event_channel, event_kind,
                  input ready);
  modport sink   (input valid, action, event_count, event_channel, event_kind,
                  output ready);
endinterface

interface setb_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  occupancy;
  logic [15:0] first_compare;
  logic [15:0] return_compare;

  modport source (output valid, status, occupancy, first_compare, return_compare,
                  input ready);
  modport sink   (input valid, status, occupancy, first_compare, return_compare,
                  output ready);
endinterface

### design/sorted_encoder_event_table.sv
// Top level of the sorted encoder event table: a chain of event cells,
// occupancy and compare registers, result register. Uses setb_pkg, setb_if.
//
//   channel   dir   handshake        payload
//   evt_i     in    valid/ready      action, event_count, event_channel, event_kind
//   res_o     out   valid/ready      status, occupancy, first_compare, return_compare
//   cfg       in    cfg_we_i         cfg_wdata_i (return_offset)
//
// One word a cycle: every cell compares and shifts in the cycle the word is taken.
// The result appears in the cycle after; the chain's found and last-count ripple
// sets the clock path. Reset clears all valid bits and held, compare, offset.
// A stalled result holds res_o and blocks evt_i only while it waits.
`timescale 1ns / 1ps
`include "sorted_encoder_event_table_macros.svh"
module sorted_encoder_event_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  setb_evt_if.sink    evt_i,
  setb_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import setb_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  cell_out_t   chain [CAPACITY];
  cell_out_t   bound;
  op_t         op;
  logic        fire;
  logic        full;
  logic        found;
  logic [CW-1:0] held_q, held_d;
  logic [15:0] fwd_q, fwd_d;
  logic [15:0] rev_q, rev_d;
  logic [15:0] offset_q;
  status_e     status_d;
  logic        out_valid_q;
  status_e     status_q;
  logic [6:0]  occ_q;
  action_e     act;

  assign bound = '0;
  assign act   = action_e'(evt_i.action);
  assign fire  = evt_i.valid && evt_i.ready;
  assign full  = chain[CAPACITY-1].valid;
  assign found = chain[CAPACITY-1].found;

  assign evt_i.ready = !out_valid_q || res_o.ready;

  assign op.clear       = fire && (act == ACT_CLEAR);
  assign op.insert      = fire && (act == ACT_INSERT) && !full;
  assign op.remove      = fire && (act == ACT_REMOVE);
  assign op.ent.count   = evt_i.event_count;
  assign op.ent.channel = evt_i.event_channel;
  assign op.ent.kind    = evt_i.event_kind;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_out_t left_c;
    cell_out_t right_c;
    if (i == 0) begin : g_head
      assign left_c = bound;
    end else begin : g_mid
      assign left_c = chain[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_c = bound;
    end else begin : g_body
      assign right_c = chain[i+1];
    end
    setb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .left_i  (left_c),
      .right_i (right_c),
      .cell_o  (chain[i])
    );
  end

  always_comb begin
    held_d   = held_q;
    fwd_d    = fwd_q;
    rev_d    = rev_q;
    status_d = ST_DONE;
    case (act)
      ACT_CLEAR: begin
        held_d = '0;
      end
      ACT_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          held_d = held_q + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          held_d = held_q - CW'(1);
        end else begin
          status_d = ST_MISSING;
        end
      end
      ACT_REWIND: begin
        if (chain[0].valid) begin
          fwd_d = chain[0].ent.count;
        end
        if (chain[1].valid) begin
          rev_d = chain[0].last - offset_q;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      fwd_q       <= '0;
      rev_q       <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (fire) begin
        held_q <= held_d;
        fwd_q  <= fwd_d;
        rev_q  <= rev_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      occ_q    <= 7'(held_d);
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.status         = status_q;
  assign res_o.occupancy      = occ_q;
  assign res_o.first_compare  = fwd_q;
  assign res_o.return_compare = rev_q;

  `SETB_ASSERT(a_held_bound, clk_i, rst_ni, held_q <= CW'(CAPACITY), "occupancy past capacity")
  `SETB_ASSERT(a_head_valid, clk_i, rst_ni, chain[0].valid == (held_q != '0), "head cell out of step")
  `SETB_ASSERT(a_tail_valid, clk_i, rst_ni, full == (held_q == CW'(CAPACITY)), "tail cell out of step")
  `SETB_ASSERT(a_full_drop, clk_i, rst_ni, fire && (act == ACT_INSERT) && full |=> status_q == ST_FULL && $stable(held_q), "insert into full table not dropped")
  `SETB_ASSERT_NEVER(a_ready_stall, clk_i, rst_ni, evt_i.ready && out_valid_q && !res_o.ready, "word taken over a stalled result")

endmodule

### design/setb_cell.sv
// One cell of the sorted chain: holds a single event and its valid bit.
// Depends on setb_pkg; takes data from its left or right neighbour.
`timescale 1ns / 1ps
module setb_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  setb_pkg::op_t         op_i,
  input  setb_pkg::cell_out_t   left_i,
  input  setb_pkg::cell_out_t   right_i,
  output setb_pkg::cell_out_t   cell_o
);
  import setb_pkg::*;

  logic   valid_q, valid_d;
  entry_t ent_q, ent_d;
  logic   after;
  logic   found;

  assign after = !valid_q || (ent_q.count > op_i.ent.count);
  assign found = left_i.found || (valid_q && (ent_q == op_i.ent));

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (op_i.clear) begin
      valid_d = 1'b0;
    end else if (op_i.insert && after) begin
      if (left_i.after) begin
        valid_d = left_i.valid;
        ent_d   = left_i.ent;
      end else begin
        valid_d = 1'b1;
        ent_d   = op_i.ent;
      end
    end else if (op_i.remove && found) begin
      valid_d = right_i.valid;
      ent_d   = right_i.ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.ent   = ent_q;
  assign cell_o.after = after;
  assign cell_o.found = found;
  assign cell_o.last  = right_i.valid ? right_i.last : ent_q.count;

endmodule

### tb/sorted_encoder_event_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted encoder event table: watches the event, result and register
// ports, keeps its own sorted copy of the table and compares every result word.
// Depends on setb_pkg and the channel interfaces in setb_if.
module sorted_encoder_event_table_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  setb_evt_if         evt_i,
  setb_res_if         res_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import setb_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [6:0]  occupancy;
    logic [15:0] first_compare;
    logic [15:0] return_compare;
  } result_t;

  entry_t      table_q [CAPACITY];
  int unsigned held;
  logic [15:0] fwd_cmp;
  logic [15:0] rev_cmp;
  logic [15:0] return_offset;
  result_t     results_due_q[$];
  int          fails = 0;
  int          pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic status_e insert_event(entry_t ent);
    int unsigned pos;
    int unsigned i;
    if (held >= CAPACITY) return ST_FULL;
    pos = 0;
    while (pos < held && table_q[pos].count <= ent.count) pos++;
    for (i = held; i > pos; i--) table_q[i] = table_q[i - 1];
    table_q[pos] = ent;
    held++;
    return ST_DONE;
  endfunction

  function automatic status_e remove_event(entry_t ent);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < held && table_q[pos] != ent) pos++;
    if (pos >= held) return ST_MISSING;
    for (i = pos; i + 1 < held; i++) table_q[i] = table_q[i + 1];
    held--;
    table_q[held] = '0;
    return ST_DONE;
  endfunction

  function automatic result_t apply_word(action_e act, entry_t ent);
    result_t r;
    int      i;
    r.status = ST_DONE;
    case (act)
      ACT_CLEAR: begin
        for (i = 0; i < CAPACITY; i++) table_q[i] = '0;
        held = 0;
      end
      ACT_INSERT: r.status = insert_event(ent);
      ACT_REMOVE: r.status = remove_event(ent);
      default: begin
        if (held > 0) begin
          fwd_cmp = table_q[0].count;
          if (held >= 2) rev_cmp = table_q[held - 1].count - return_offset;
        end
      end
    endcase
    r.occupancy      = 7'(held);
    r.first_compare  = fwd_cmp;
    r.return_compare = rev_cmp;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    entry_t  word;
    int      i;
    if (!rst_ni) begin
      for (i = 0; i < CAPACITY; i++) table_q[i] = '0;
      held          = 0;
      fwd_cmp       = '0;
      rev_cmp       = '0;
      return_offset = '0;
      results_due_q.delete();
      pending       = 0;
    end else begin
      if (cfg_we_i) return_offset = cfg_wdata_i;
      if (evt_i.valid && evt_i.ready) begin
        word = {evt_i.event_count, evt_i.event_channel, evt_i.event_kind};
        results_due_q.push_back(apply_word(action_e'(evt_i.action), word));
      end
      if (res_i.valid && res_i.ready) begin
        if (results_due_q.size() == 0) begin
          $error("result word with nothing due: status %0d occupancy %0d",
                 res_i.status, res_i.occupancy);
          fails++;
        end else begin
          due = results_due_q.pop_front();
          if (res_i.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, res_i.status);
            fails++;
          end
          if (res_i.occupancy !== due.occupancy) begin
            $error("occupancy: expected %0d, got %0d", due.occupancy, res_i.occupancy);
            fails++;
          end
          if (res_i.first_compare !== due.first_compare) begin
            $error("first_compare: expected %0d, got %0d",
                   due.first_compare, res_i.first_compare);
            fails++;
          end
          if (res_i.return_compare !== due.return_compare) begin
            $error("return_compare: expected %0d, got %0d",
                   due.return_compare, res_i.return_compare);
            fails++;
          end
        end
      end
      pending = results_due_q.size();
    end
  end

endmodule

### tb/sorted_encoder_event_table_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sorted encoder event table: drives event words and offset
// writes, stalls the result port and gives the verdict.
// Depends on setb_pkg, setb_if, the block and sorted_encoder_event_table_checker.
module sorted_encoder_event_table_tb;
  import setb_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 160;
  localparam int FILL_WORDS     = 110;

  localparam logic [1:0] KIND_KEEP     = 2'd0;
  localparam logic [1:0] KIND_ON       = 2'd1;
  localparam logic [1:0] KIND_OFF_HIGH = 2'd2;
  localparam logic [1:0] KIND_OFF_LOW  = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  int          fail_count;
  int          pending;
  entry_t      live_q[$];

  setb_evt_if evt_if();
  setb_res_if res_if();

  sorted_encoder_event_table #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  sorted_encoder_event_table_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_if),
    .res_i       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(action_e act, entry_t ent);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_if.valid         <= 1'b1;
    evt_if.action        <= act;
    evt_if.event_count   <= ent.count;
    evt_if.event_channel <= ent.channel;
    evt_if.event_kind    <= ent.kind;
    do @(posedge clk_i); while (!evt_if.ready);
  endtask

  // hold off until every result word is back
  task automatic drain();
    @(negedge clk_i);
    evt_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_offset(logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_word(bit filling);
    int      roll;
    int      idx;
    entry_t  ent;
    action_e act;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       ent.count = 16'($urandom_range(0, 15));
      1:       ent.count = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: ent.count = 16'($urandom);
    endcase
    ent.channel = 4'($urandom);
    ent.kind    = 2'($urandom);
    if (filling) begin
      act = roll < 85 ? ACT_INSERT : roll < 93 ? ACT_REMOVE : ACT_REWIND;
    end else begin
      act = roll < 55 ? ACT_REMOVE : roll < 70 ? ACT_INSERT :
            roll < 90 ? ACT_REWIND : ACT_CLEAR;
    end
    // aim most removes at held entries, some with a wrong kind
    if (act == ACT_REMOVE && live_q.size() > 0 && $urandom_range(0, 99) < 80) begin
      idx = $urandom_range(0, live_q.size() - 1);
      ent = live_q[idx];
      if ($urandom_range(0, 99) < 15) begin
        ent.kind = ent.kind ^ 2'd1;
      end else begin
        live_q.delete(idx);
      end
    end
    send_word(act, ent);
    if (act == ACT_INSERT && live_q.size() < CAPACITY) live_q.push_back(ent);
    if (act == ACT_CLEAR) live_q.delete();
  endtask

  initial begin
    int          p;
    int          n;
    logic [15:0] offsets [4];
    int          idle_set [4];
    int          stall_set [4];
    offsets   = '{16'h0000, 16'($urandom), 16'h0001, 16'h8000};
    idle_set  = '{0, 51, 0, 23};
    stall_set = '{0, 0, 51, 23};

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    evt_if.valid         = 1'b0;
    evt_if.action        = ACT_CLEAR;
    evt_if.event_count   = '0;
    evt_if.event_channel = '0;
    evt_if.event_kind    = '0;
    res_if.ready         = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_offset(16'hFFFF);
    send_word(ACT_REWIND, '{16'hFFFF, 4'hF, KIND_OFF_LOW});
    send_word(ACT_REMOVE, '{16'h1234, 4'h3, KIND_ON});
    send_word(ACT_INSERT, '{16'hFFFF, 4'hF, KIND_OFF_LOW});
    send_word(ACT_REWIND, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_INSERT, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_INSERT, '{16'h8000, 4'h5, KIND_ON});
    send_word(ACT_INSERT, '{16'h8000, 4'hA, KIND_OFF_HIGH});
    send_word(ACT_INSERT, '{16'h8000, 4'h5, KIND_ON});
    send_word(ACT_REWIND, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_REMOVE, '{16'h8000, 4'hA, KIND_ON});
    send_word(ACT_REMOVE, '{16'h8000, 4'h5, KIND_ON});
    send_word(ACT_REMOVE, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_REWIND, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_REMOVE, '{16'hFFFF, 4'hF, KIND_OFF_LOW});
    send_word(ACT_REWIND, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_CLEAR, '{16'hFFFF, 4'hF, KIND_OFF_LOW});
    send_word(ACT_REWIND, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_REMOVE, '{16'h8000, 4'hA, KIND_OFF_HIGH});
    send_word(ACT_INSERT, '{16'h0001, 4'h8, KIND_OFF_HIGH});
    send_word(ACT_REWIND, '{16'h0000, 4'h0, KIND_KEEP});
    send_word(ACT_CLEAR, '{16'h0000, 4'h0, KIND_KEEP});

    for (p = 0; p < 4; p++) begin
      drain();
      write_offset(offsets[p]);
      sender_idle_pct = idle_set[p];
      stall_pct       = stall_set[p];
      for (n = 0; n < PHASE_WORDS; n++) random_word(n < FILL_WORDS);
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
